FILE: sv/ptrd_pkg.sv
// ----------------------------------------------------------------------------
// ptrd_pkg
// Shared types, constants and helper functions of the planar tile row decoder.
// ----------------------------------------------------------------------------
package ptrd_pkg;

    localparam int VRAM_ADDR_BITS = 16;
    localparam int VRAM_DEPTH     = 1 << VRAM_ADDR_BITS;

    // Configuration register indexes.
    localparam logic [2:0] REG_SCREEN_MODE  = 3'd0;
    localparam logic [2:0] REG_LAYER        = 3'd1;
    localparam logic [2:0] REG_DEPTH_SELECT = 3'd2;
    localparam logic [2:0] REG_BIG_TILES    = 3'd3;
    localparam logic [2:0] REG_TILE_BASE    = 3'd4;

    // Depth select codes.
    localparam logic [2:0] DSEL_2BPP  = 3'd0;
    localparam logic [2:0] DSEL_4BPP  = 3'd1;
    localparam logic [2:0] DSEL_8BPP  = 3'd2;
    localparam logic [2:0] DSEL_MODE7 = 3'd3;

    localparam logic [2:0] MODE_7 = 3'd7;

    // Input commands.
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_RENDER = 1'b1;

    typedef enum logic [1:0] {
        DEPTH_NONE = 2'd0,
        DEPTH_2    = 2'd1,
        DEPTH_4    = 2'd2,
        DEPTH_8    = 2'd3
    } t_depth;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAP_LO,
        ST_MAP_HI,
        ST_ENTRY,
        ST_FETCH,
        ST_FETCH_WAIT,
        ST_DECODE,
        ST_OUTPUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_cmd;     // capture the input beat
        logic       vram_write;   // write the captured byte
        logic       rd_map_lo;    // read low map byte
        logic       rd_map_hi;    // read high map byte
        logic       cap_map_lo;   // capture low map byte
        logic       cap_map_hi;   // capture high map byte
        logic       calc_base;    // compute character row address
        logic       rd_plane;     // read plane byte at fetch index
        logic       cap_plane;    // store returned plane byte
        logic [2:0] plane_idx;    // fetch index being read
        logic [2:0] cap_idx;      // fetch index being captured
        logic       decode;       // form the output row
        logic       blank;        // all-transparent row
    } t_ctrl;

    // Status from the datapath.
    typedef struct packed {
        logic       is_render;
        logic       mode7;
        t_depth     depth;
    } t_stat;

    // Depth from the mode/layer table.
    function automatic t_depth depth_lookup(input logic [2:0] mode, input logic [1:0] lay);
        t_depth d;
        d = DEPTH_NONE;
        unique case (mode)
            3'd0: d = DEPTH_2;
            3'd1: d = (lay == 2'd3) ? DEPTH_NONE : (lay == 2'd2) ? DEPTH_2 : DEPTH_4;
            3'd2: d = (lay[1]) ? DEPTH_NONE : DEPTH_4;
            3'd3: d = (lay[1]) ? DEPTH_NONE : (lay[0] ? DEPTH_4 : DEPTH_8);
            3'd4: d = (lay[1]) ? DEPTH_NONE : (lay[0] ? DEPTH_2 : DEPTH_8);
            3'd5: d = (lay[1]) ? DEPTH_NONE : (lay[0] ? DEPTH_2 : DEPTH_4);
            3'd6: d = (lay == 2'd0) ? DEPTH_4 : DEPTH_NONE;
            default: d = DEPTH_NONE;
        endcase
        return d;
    endfunction

    // Number of bytes to fetch for one row.
    function automatic logic [3:0] fetch_count(input logic m7, input t_depth d);
        logic [3:0] n;
        n = 4'd2;
        if (m7) begin
            n = 4'd8;
        end else begin
            unique case (d)
                DEPTH_8: n = 4'd8;
                DEPTH_4: n = 4'd4;
                default: n = 4'd2;
            endcase
        end
        return n;
    endfunction

endpackage

FILE: sv/planar_tile_row_decoder_core.sv
// ----------------------------------------------------------------------------
// planar_tile_row_decoder_core
// Flow: a write is accepted in IDLE and written in MAP_LO; a render reads the two
// map bytes, forms the row address, fetches N bytes (2, 4 or 8) through the single
// RAM port, decodes, and holds the row in OUTPUT until taken. One item at a time;
// an invalid-depth row goes blank to OUTPUT. Reset: synchronous active low; resets
// the controller and the configuration registers. Video RAM is undefined until written.
// ----------------------------------------------------------------------------
module planar_tile_row_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command[0], vram_addr[16:1], vram_data[24:17], cell_row[28:25], right_half[29]
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pixel_0[7:0] .. pixel_7[63:56], opaque_mask[71:64]
    output logic [71:0] m_axis_tdata
);
    import ptrd_pkg::*;

    t_ctrl w_ctrl;
    t_stat w_stat;

    ptrd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_ctrl      (w_ctrl)
    );

    ptrd_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_command    (s_axis_tdata[0]),
        .i_vram_addr  (s_axis_tdata[16:1]),
        .i_vram_data  (s_axis_tdata[24:17]),
        .i_cell_row   (s_axis_tdata[28:25]),
        .i_right_half (s_axis_tdata[29]),
        .i_ctrl       (w_ctrl),
        .o_stat       (w_stat),
        .o_result     (m_axis_tdata)
    );

endmodule

FILE: sv/ptrd_ram.sv
// ----------------------------------------------------------------------------
// ptrd_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module ptrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One access per cycle: a registered read, plus a write when i_we is set.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/ptrd_datapath.sv
// ----------------------------------------------------------------------------
// ptrd_datapath
// Video RAM, configuration registers, address generation and row decode.
// ----------------------------------------------------------------------------
module ptrd_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_index,
    input  logic [15:0]    i_cfg_data,
    input  logic           i_command,
    input  logic [15:0]    i_vram_addr,
    input  logic [7:0]     i_vram_data,
    input  logic [3:0]     i_cell_row,
    input  logic           i_right_half,
    input  ptrd_pkg::t_ctrl i_ctrl,
    output ptrd_pkg::t_stat o_stat,
    output logic [71:0]    o_result
);
    import ptrd_pkg::*;

    // Configuration registers.
    logic [2:0]  r_screen_mode;
    logic [1:0]  r_layer;
    logic [2:0]  r_depth_select;
    logic        r_big_tiles;
    logic [15:0] r_tile_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_mode  <= '0;
            r_layer        <= '0;
            r_depth_select <= 3'd4;
            r_big_tiles    <= 1'b0;
            r_tile_base    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SCREEN_MODE:  r_screen_mode  <= i_cfg_data[2:0];
                REG_LAYER:        r_layer        <= i_cfg_data[1:0];
                REG_DEPTH_SELECT: r_depth_select <= i_cfg_data[2:0];
                REG_BIG_TILES:    r_big_tiles    <= i_cfg_data[0];
                REG_TILE_BASE:    r_tile_base    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Captured command.
    logic        r_cmd;
    logic [15:0] r_addr;
    logic [7:0]  r_data;
    logic [3:0]  r_row;
    logic        r_right;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_cmd) begin
            r_cmd   <= i_command;
            r_addr  <= i_vram_addr;
            r_data  <= i_vram_data;
            r_row   <= i_cell_row;
            r_right <= i_right_half;
        end
    end

    // Mode and depth decision.
    logic   w_mode7;
    t_depth w_depth;
    always_comb begin
        w_mode7 = (r_screen_mode == MODE_7) || (r_depth_select == DSEL_MODE7);
        unique case (r_depth_select)
            DSEL_2BPP: w_depth = DEPTH_2;
            DSEL_4BPP: w_depth = DEPTH_4;
            DSEL_8BPP: w_depth = DEPTH_8;
            default:   w_depth = depth_lookup(r_screen_mode, r_layer);
        endcase
    end

    assign o_stat.is_render = (r_cmd == CMD_RENDER);
    assign o_stat.mode7     = w_mode7;
    assign o_stat.depth     = w_depth;

    // Map entry capture.
    logic [15:0] r_entry;
    logic [7:0]  w_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.cap_map_lo) r_entry[7:0]  <= w_rdata;
        if (i_ctrl.cap_map_hi) r_entry[15:8] <= w_rdata;
    end

    // Sub-tile choice and character row address.
    logic [15:0] r_base;
    logic [10:0] w_ch;
    logic [2:0]  w_srow;
    logic [15:0] w_caddr;
    always_comb begin
        logic [10:0] c1, c2, c3, c4, t;
        logic        hf, vf;
        hf = r_entry[14];
        vf = r_entry[15];
        w_ch = {1'b0, r_entry[9:0]};
        if (r_big_tiles) begin
            c1 = {1'b0, r_entry[9:0]};
            c2 = {1'b0, r_entry[9:4], 4'(r_entry[3:0] + 4'd1)};
            if (hf) begin
                t = c1; c1 = c2; c2 = t;
            end
            c3 = c1 + 11'h10;
            c4 = c2 + 11'h10;
            if (vf) begin
                t = c1; c1 = c3; c3 = t;
                t = c2; c2 = c4; c4 = t;
            end
            if (!r_row[3]) w_ch = r_right ? c2 : c1;
            else           w_ch = r_right ? c4 : c3;
        end
        w_srow = vf ? 3'(3'd7 - r_row[2:0]) : r_row[2:0];
        unique case (w_depth)
            DEPTH_8: w_caddr = (r_tile_base + {w_ch[9:0], 6'd0}) & 16'hFFC0;
            DEPTH_4: w_caddr = (r_tile_base + {w_ch[10:0], 5'd0}) & 16'hFFE0;
            default: w_caddr = (r_tile_base + {1'b0, w_ch[10:0], 4'd0}) & 16'hFFF0;
        endcase
    end

    // Mode 7 rows start at char * 128 + 1 + row * 16.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.calc_base) begin
            if (w_mode7) r_base <= {1'b0, r_entry[7:0], 7'd1} + {9'd0, r_row[2:0], 4'd0};
            else         r_base <= w_caddr + {12'd0, w_srow, 1'b0};
        end
    end

    // Plane or pixel byte address for a fetch index.
    logic [15:0] w_faddr;
    always_comb begin
        if (w_mode7) begin
            w_faddr = r_base + {12'd0, i_ctrl.plane_idx, 1'b0};
        end else begin
            w_faddr = r_base + {10'd0, i_ctrl.plane_idx[2:1], 4'd0}
                      + {15'd0, i_ctrl.plane_idx[0]};
        end
    end

    // Memory port.
    logic        w_we;
    logic [15:0] w_maddr;
    always_comb begin
        w_we = i_ctrl.vram_write;
        if (i_ctrl.vram_write)     w_maddr = r_addr;
        else if (i_ctrl.rd_map_lo) w_maddr = r_addr;
        else if (i_ctrl.rd_map_hi) w_maddr = r_addr + 16'd1;
        else                       w_maddr = w_faddr;
    end

    ptrd_ram #(.WIDTH(8), .DEPTH(VRAM_DEPTH)) u_vram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_maddr),
        .i_wdata (r_data),
        .o_rdata (w_rdata)
    );

    // Fetched bytes.
    logic [7:0] r_plane [8];
    always_ff @(posedge i_clk) begin
        if (i_ctrl.cap_plane) r_plane[i_ctrl.cap_idx] <= w_rdata;
    end

    // Row decode into destination columns.
    logic [71:0] r_result;
    always_ff @(posedge i_clk) begin
        logic [7:0] raw, off, mask;
        logic [2:0] sx;
        if (i_ctrl.decode) begin
            mask = '0;
            unique case (w_depth)
                DEPTH_2: off = {3'd0, r_entry[12:10], 2'd0}
                               + ((r_screen_mode == 3'd0) ? {1'b0, r_layer, 5'd0} : 8'd0);
                DEPTH_4: off = {1'b0, r_entry[12:10], 4'd0};
                default: off = 8'd0;
            endcase
            for (int x = 0; x < 8; x++) begin
                if (w_mode7) begin
                    raw = r_plane[x];
                    if (raw != 8'd0) mask[x] = 1'b1;
                    r_result[x*8 +: 8] <= raw;
                end else begin
                    sx = r_entry[14] ? 3'(7 - x) : 3'(x);
                    for (int k = 0; k < 8; k++) begin
                        raw[k] = r_plane[k][3'(7 - int'(sx))];
                    end
                    if (w_depth != DEPTH_8) raw[7:4] = 4'd0;
                    if (w_depth == DEPTH_2) raw[3:2] = 2'd0;
                    if (raw != 8'd0) mask[x] = 1'b1;
                    r_result[x*8 +: 8] <= (raw != 8'd0) ? 8'(raw + off) : 8'd0;
                end
            end
            r_result[71:64] <= mask;
        end else if (i_ctrl.blank) begin
            r_result <= '0;
        end
    end

    assign o_result = r_result;

endmodule

FILE: sv/ptrd_ctrl.sv
// ----------------------------------------------------------------------------
// ptrd_ctrl
// Sequencer for write and render commands and the output handshake.
// ----------------------------------------------------------------------------
module ptrd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  ptrd_pkg::t_stat i_stat,
    output ptrd_pkg::t_ctrl o_ctrl
);
    import ptrd_pkg::*;

    t_state     r_state, n_state;
    logic [3:0] r_idx, n_idx;
    logic [3:0] w_count;

    assign w_count = fetch_count(i_stat.mode7, i_stat.depth);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        o_ctrl      = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_ctrl.plane_idx = r_idx[2:0];
        o_ctrl.cap_idx   = 3'(r_idx - 4'd1);
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctrl.load_cmd = 1'b1;
                    n_state = ST_MAP_LO;
                end
            end
            ST_MAP_LO: begin
                if (!i_stat.is_render) begin
                    o_ctrl.vram_write = 1'b1;
                    n_state = ST_IDLE;
                end else if (!i_stat.mode7 && i_stat.depth == DEPTH_NONE) begin
                    o_ctrl.blank = 1'b1;
                    n_state = ST_OUTPUT;
                end else begin
                    o_ctrl.rd_map_lo = 1'b1;
                    n_state = ST_MAP_HI;
                end
            end
            ST_MAP_HI: begin
                o_ctrl.cap_map_lo = 1'b1;
                o_ctrl.rd_map_hi  = 1'b1;
                n_state = ST_ENTRY;
            end
            ST_ENTRY: begin
                o_ctrl.cap_map_hi = 1'b1;
                n_idx   = '0;
                n_state = ST_FETCH;
            end
            ST_FETCH: begin
                // This state computes the row address; the plane reads follow in FETCH_WAIT.
                o_ctrl.calc_base = 1'b1;
                n_state = ST_FETCH_WAIT;
            end
            ST_FETCH_WAIT: begin
                if (r_idx != 4'd0) o_ctrl.cap_plane = 1'b1;
                if (r_idx == w_count) begin
                    n_state = ST_DECODE;
                end else begin
                    o_ctrl.rd_plane = 1'b1;
                    n_idx = r_idx + 4'd1;
                end
            end
            ST_DECODE: begin
                o_ctrl.decode = 1'b1;
                n_state = ST_OUTPUT;
            end
            ST_OUTPUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the planar tile row decoder. A short directed table
// exercises extremes, flips, every depth and the invalid-depth row; then
// randomized phases write video RAM and render rows under changing register
// settings. Each render is predicted locally or taken from the table, and compared field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import ptrd_pkg::*;

    // Each random render first writes any byte it reads that was never written, so a
    // phase can send more beats than it has loop steps.
    localparam int NUM_PHASES = 10;
    localparam int PHASE_ITEMS = 32;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;

    planar_tile_row_decoder_core u_top (.*);

    always #5 i_clk = ~i_clk;

    // Local image of video RAM and of the register file.
    logic [7:0]  vram_img [0:65535];
    bit          vram_set [0:65535];
    logic [2:0]  cfg_mode = 3'd0;
    logic [1:0]  cfg_layer = 2'd0;
    logic [2:0]  cfg_dsel = 3'd4;
    logic        cfg_big = 1'b0;
    logic [15:0] cfg_base = 16'd0;

    logic [15:0] fetched_addrs [$];
    logic [71:0] pending_rows [$];
    int          fail_count = 0;
    bit          quiet = 1'b0;
    int          stall_left = 0;

    typedef enum {D_CFG, D_WR, D_RD} t_drow_kind;
    typedef struct {
        t_drow_kind  kind;
        logic [15:0] a;
        logic [15:0] d;
        logic [3:0]  r;
        logic        rh;
        bit          chk;
        logic [71:0] exp;
    } t_drow;
    t_drow directed [$];

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 20) $display("mismatch @%0t: %s", $realtime, msg);
    endtask

    // Every video RAM read of the predictor goes through here, so a render can
    // first list the bytes it will touch.
    function automatic logic [7:0] vram_rd(input logic [15:0] a);
        fetched_addrs.push_back(a);
        return vram_img[a];
    endfunction

    // Expected pixel row for a render beat under the current registers.
    function automatic logic [71:0] predict_row(input logic [15:0] addr, input logic [3:0] row,
                                                input logic right);
        logic [71:0] res;
        logic [15:0] entry, base, pa;
        logic [7:0]  ch7, pix, off, raw;
        logic [10:0] ch, c1, c2, c3, c4, t;
        logic [2:0]  pal, srow, sx;
        logic        hf, vf;
        logic [7:0]  planes [8];
        int          depth, x, k;
        res = '0;
        if (cfg_mode == MODE_7 || cfg_dsel == DSEL_MODE7) begin
            ch7 = vram_rd(addr);
            for (x = 0; x < 8; x++) begin
                pa = 16'(ch7) * 16'd128 + 16'd1 + 16'(row[2:0]) * 16'd16 + 16'(x * 2);
                pix = vram_rd(pa);
                res[x*8 +: 8] = pix;
                res[64 + x] = (pix != 8'd0);
            end
            return res;
        end
        case (cfg_dsel)
            DSEL_2BPP: depth = 2;
            DSEL_4BPP: depth = 4;
            DSEL_8BPP: depth = 8;
            default: begin
                case (cfg_mode)
                    3'd0: depth = 2;
                    3'd1: depth = (cfg_layer == 2'd3) ? 0 : (cfg_layer == 2'd2) ? 2 : 4;
                    3'd2: depth = cfg_layer[1] ? 0 : 4;
                    3'd3: depth = cfg_layer[1] ? 0 : (cfg_layer[0] ? 4 : 8);
                    3'd4: depth = cfg_layer[1] ? 0 : (cfg_layer[0] ? 2 : 8);
                    3'd5: depth = cfg_layer[1] ? 0 : (cfg_layer[0] ? 2 : 4);
                    3'd6: depth = (cfg_layer == 2'd0) ? 4 : 0;
                    default: depth = 0;
                endcase
            end
        endcase
        if (depth == 0) return res;
        entry = {vram_rd(addr + 16'd1), vram_rd(addr)};
        ch  = {1'b0, entry[9:0]};
        pal = entry[12:10];
        hf  = entry[14];
        vf  = entry[15];
        if (depth == 2) off = 8'(pal * 4) + (cfg_mode == 3'd0 ? 8'(cfg_layer * 32) : 8'd0);
        else if (depth == 4) off = 8'(pal * 16);
        else off = 8'd0;
        // Large cells: pick one of four sub-tiles, swapped by the flips.
        if (cfg_big) begin
            c1 = ch;
            c2 = {ch[10:4], 4'(ch[3:0] + 4'd1)};
            if (hf) begin
                t = c1; c1 = c2; c2 = t;
            end
            c3 = c1 + 11'd16;
            c4 = c2 + 11'd16;
            if (vf) begin
                t = c1; c1 = c3; c3 = t;
                t = c2; c2 = c4; c4 = t;
            end
            ch = row[3] ? (right ? c4 : c3) : (right ? c2 : c1);
        end
        srow = vf ? 3'd7 - row[2:0] : row[2:0];
        if (depth == 8) base = (cfg_base + 16'(ch) * 16'd64) & 16'hFFC0;
        else if (depth == 4) base = (cfg_base + 16'(ch) * 16'd32) & 16'hFFE0;
        else base = (cfg_base + 16'(ch) * 16'd16) & 16'hFFF0;
        base = base + 16'(srow) * 16'd2;
        for (k = 0; k < 8; k++) planes[k] = 8'd0;
        planes[0] = vram_rd(base);
        planes[1] = vram_rd(base + 16'd1);
        if (depth >= 4) begin
            planes[2] = vram_rd(base + 16'd16);
            planes[3] = vram_rd(base + 16'd17);
        end
        if (depth == 8) begin
            planes[4] = vram_rd(base + 16'd32);
            planes[5] = vram_rd(base + 16'd33);
            planes[6] = vram_rd(base + 16'd48);
            planes[7] = vram_rd(base + 16'd49);
        end
        for (x = 0; x < 8; x++) begin
            sx = hf ? 3'(7 - x) : 3'(x);
            for (k = 0; k < 8; k++) raw[k] = planes[k][3'd7 - sx];
            if (raw != 8'd0) begin
                res[x*8 +: 8] = raw + off;
                res[64 + x] = 1'b1;
            end
        end
        return res;
    endfunction

    // Present one input beat; called right after a rising edge, returns at the
    // edge that accepted it with tvalid still high.
    task automatic drive_beat(input logic cmd, input logic [15:0] a, input logic [7:0] d,
                              input logic [3:0] r, input logic rh);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, rh, r, d, a, cmd};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_write(input logic [15:0] a, input logic [7:0] d);
        vram_img[a] = d;
        vram_set[a] = 1'b1;
        drive_beat(CMD_WRITE, a, d, 4'($urandom), 1'($urandom));
    endtask

    // Fill any byte the row would read that was never written, then render.
    task automatic send_render(input logic [15:0] a, input logic [3:0] r, input logic rh,
                               input bit chk, input logic [71:0] typed);
        logic [71:0] exp;
        bit          miss;
        int          pass;
        for (pass = 0; pass < 4; pass++) begin
            fetched_addrs.delete();
            exp = predict_row(a, r, rh);
            miss = 1'b0;
            foreach (fetched_addrs[i]) begin
                if (!vram_set[fetched_addrs[i]]) begin
                    miss = 1'b1;
                    send_write(fetched_addrs[i], 8'($urandom));
                end
            end
            if (!miss) break;
        end
        pending_rows.push_back(chk ? typed : exp);
        drive_beat(CMD_RENDER, a, 8'($urandom), r, rh);
    endtask

    // Registers change only with the block idle.
    task automatic write_cfg(input logic [2:0] idx, input logic [15:0] v);
        s_axis_tvalid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_SCREEN_MODE:  cfg_mode  = v[2:0];
            REG_LAYER:        cfg_layer = v[1:0];
            REG_DEPTH_SELECT: cfg_dsel  = v[2:0];
            REG_BIG_TILES:    cfg_big   = v[0];
            REG_TILE_BASE:    cfg_base  = v;
            default: ;
        endcase
    endtask

    task automatic add_row(input t_drow_kind kind, input logic [15:0] a, input logic [15:0] d,
                           input logic [3:0] r, input logic rh, input bit chk,
                           input logic [71:0] exp);
        t_drow row;
        row = '{kind, a, d, r, rh, chk, exp};
        directed.push_back(row);
    endtask

    // Result side: random stall bursts, checking of every accepted beat.
    always @(posedge i_clk) begin
        logic [71:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_rows.size() == 0) begin
                report_mismatch("result beat with no render outstanding");
            end else begin
                want = pending_rows.pop_front();
                for (int f = 0; f < 9; f++) begin
                    if (m_axis_tdata[f*8 +: 8] !== want[f*8 +: 8])
                        report_mismatch($sformatf("%s got %02h want %02h",
                            f < 8 ? $sformatf("pixel_%0d", f) : "opaque_mask",
                            m_axis_tdata[f*8 +: 8], want[f*8 +: 8]));
                end
            end
        end
        if (quiet) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 18);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        logic [15:0] win, a;
        for (int i = 0; i < 65536; i++) vram_set[i] = 1'b0;

        // Directed table: known pixels, transparency, wrap, flips, every depth.
        add_row(D_WR, 16'h8000, 16'h00, 4'd0, 1'b0, 0, '0);
        add_row(D_WR, 16'h8001, 16'h00, 4'd0, 1'b0, 0, '0);
        add_row(D_WR, 16'h0000, 16'hFF, 4'd0, 1'b0, 0, '0);
        add_row(D_WR, 16'h0001, 16'h00, 4'd0, 1'b0, 0, '0);
        add_row(D_RD, 16'h8000, 16'h00, 4'd0, 1'b0, 1, {8'hFF, {8{8'h01}}});
        add_row(D_WR, 16'h0002, 16'h00, 4'd0, 1'b0, 0, '0);
        add_row(D_WR, 16'h0003, 16'h00, 4'd0, 1'b0, 0, '0);
        add_row(D_RD, 16'h8000, 16'h00, 4'd1, 1'b0, 1, '0);
        add_row(D_WR, 16'hFFFF, 16'hFF, 4'd15, 1'b1, 0, '0);
        add_row(D_RD, 16'hFFFF, 16'h00, 4'd15, 1'b1, 0, '0);
        add_row(D_WR, 16'h8002, 16'h01, 4'd0, 1'b0, 0, '0);
        add_row(D_WR, 16'h8003, 16'hC0, 4'd0, 1'b0, 0, '0);
        add_row(D_RD, 16'h8002, 16'h00, 4'd2, 1'b0, 0, '0);
        add_row(D_CFG, REG_SCREEN_MODE, 16'd1, 4'd0, 1'b0, 0, '0);
        add_row(D_CFG, REG_LAYER, 16'd3, 4'd0, 1'b0, 0, '0);
        add_row(D_RD, 16'h8000, 16'h00, 4'd0, 1'b0, 1, '0);
        add_row(D_CFG, REG_LAYER, 16'd0, 4'd0, 1'b0, 0, '0);
        add_row(D_CFG, REG_BIG_TILES, 16'd1, 4'd0, 1'b0, 0, '0);
        add_row(D_RD, 16'h8002, 16'h00, 4'd15, 1'b1, 0, '0);
        add_row(D_CFG, REG_DEPTH_SELECT, 16'd2, 4'd0, 1'b0, 0, '0);
        add_row(D_RD, 16'hFFFF, 16'h00, 4'd8, 1'b0, 0, '0);
        add_row(D_CFG, REG_DEPTH_SELECT, 16'd3, 4'd0, 1'b0, 0, '0);
        add_row(D_RD, 16'h8000, 16'h00, 4'd15, 1'b1, 0, '0);
        add_row(D_CFG, REG_TILE_BASE, 16'hFFFF, 4'd0, 1'b0, 0, '0);
        add_row(D_CFG, REG_DEPTH_SELECT, 16'd7, 4'd0, 1'b0, 0, '0);
        add_row(D_CFG, REG_SCREEN_MODE, 16'd0, 4'd0, 1'b0, 0, '0);
        add_row(D_CFG, REG_LAYER, 16'd3, 4'd0, 1'b0, 0, '0);
        add_row(D_RD, 16'h8002, 16'h00, 4'd9, 1'b0, 0, '0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            case (directed[i].kind)
                D_CFG: write_cfg(directed[i].a[2:0], directed[i].d);
                D_WR:  send_write(directed[i].a, directed[i].d[7:0]);
                default: send_render(directed[i].a, directed[i].r, directed[i].rh,
                                     directed[i].chk, directed[i].exp);
            endcase
        end

        // Random phases, each under its own register setting.
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == NUM_PHASES - 1) quiet = 1'b1;
            write_cfg(REG_SCREEN_MODE, p == 0 ? 16'd6 : p == 1 ? 16'd0 : 16'($urandom_range(0, 7)));
            write_cfg(REG_LAYER, p == 0 ? 16'd0 : 16'($urandom_range(0, 3)));
            write_cfg(REG_DEPTH_SELECT, p == 1 ? 16'd0 : 16'($urandom_range(0, 7)));
            write_cfg(REG_BIG_TILES, p == 0 ? 16'd1 : 16'($urandom_range(0, 1)));
            write_cfg(REG_TILE_BASE, p == 0 ? 16'hFFFF : p == 1 ? 16'h0000 : 16'($urandom));
            win = 16'($urandom);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Keep most traffic in a small window so rows reuse written data.
                a = ($urandom_range(0, 9) < 7) ? win + 16'($urandom_range(0, 1023))
                                               : 16'($urandom);
                if ($urandom_range(0, 99) < 35)
                    send_write(a, 8'($urandom));
                else
                    send_render(a, 4'($urandom), 1'($urandom), 0, '0);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/ptrd_pkg.sv
sv/ptrd_ram.sv
sv/ptrd_datapath.sv
sv/ptrd_ctrl.sv
sv/planar_tile_row_decoder_core.sv
tb/tb_top.sv
